// ===== src/psl_pkg.sv =====
// Package for the positional sorted list engine.
// Holds sizes, codes and the record, command, response and cell control types.
// No dependencies.
`default_nettype none

package psl_pkg;

  // List sizing
  localparam int CAPACITY     = 64;
  localparam int PAYLOAD_BITS = 32;
  localparam int IDX_W        = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);

  // Field widths of the command and response
  localparam int OP_W  = 2;
  localparam int POS_W = 7;
  localparam int KEY_W = 16;
  localparam int PLD_W = 32;
  localparam int ST_W  = 2;
  localparam int ENT_W = 7;

  // Common width for index, count and position compares
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Scan grouping for the first-match search
  localparam int GRP  = 8;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;
  localparam int NPAD = NGRP * GRP;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SORTED = 2'd3
  } psl_op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } psl_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FLAG,
    S_GROUP,
    S_APPLY
  } psl_state_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key;
    logic [PLD_W-1:0] payload;
  } psl_cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] read_key;
    logic [PLD_W-1:0] read_payload;
    logic [ENT_W-1:0] entries;
  } psl_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [PAYLOAD_BITS-1:0] payload;
  } psl_rec_t;

  // Broadcast to every cell for the flag compare
  typedef struct packed {
    logic             sorted;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] key;
  } psl_ctl_t;

  // Broadcast to every cell for the shift
  typedef struct packed {
    logic ins;
    logic rem;
  } psl_upd_t;

endpackage

`default_nettype wire

// ===== src/psl_cell.sv =====
// One list slot: holds a record, raises its match flag, shifts with its neighbors.
// Depends on psl_pkg.
`default_nettype none

module psl_cell (
  input  logic                     clk_i,
  input  logic [psl_pkg::IDX_W-1:0] idx_i,
  input  psl_pkg::psl_ctl_t        ctl_i,
  input  psl_pkg::psl_upd_t        upd_i,
  input  psl_pkg::psl_rec_t        new_i,
  input  psl_pkg::psl_rec_t        left_i,
  input  psl_pkg::psl_rec_t        right_i,
  input  logic                     mask_i,
  input  logic                     mask_left_i,
  output logic                     flag_o,
  output psl_pkg::psl_rec_t        rec_o
);
  import psl_pkg::*;

  psl_rec_t         rec_q, rec_d;
  logic [CMP_W-1:0] idx_ext, cnt_ext, pos_ext;

  assign idx_ext = CMP_W'(idx_i);
  assign cnt_ext = CMP_W'(ctl_i.count);
  assign pos_ext = CMP_W'(ctl_i.pos);

  // Sorted: slot past the end or key not smaller. Positional: slot is the target.
  always_comb begin
    if (ctl_i.sorted) begin
      flag_o = (idx_ext >= cnt_ext) || (rec_q.key >= ctl_i.key);
    end else begin
      flag_o = (idx_ext == pos_ext);
    end
  end

  // Slots at and above the target move; on insert the target slot takes the new record
  always_comb begin
    rec_d = rec_q;
    if (upd_i.ins && mask_i) begin
      rec_d = mask_left_i ? left_i : new_i;
    end else if (upd_i.rem && mask_i) begin
      rec_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

`default_nettype wire

// ===== src/psl_scan.sv =====
// Two-stage first-match search: turns per-slot flags into an at-or-after mask.
// Depends on psl_pkg.
`default_nettype none

module psl_scan (
  input  logic                         clk_i,
  input  logic [psl_pkg::CAPACITY-1:0] flags_i,
  output logic [psl_pkg::CAPACITY-1:0] mask_o
);
  import psl_pkg::*;

  logic [NPAD-1:0] flag_q;
  logic [NPAD-1:0] pre_d, pre_q;
  logic [NGRP-1:0] any_q;
  logic [NGRP-1:0] grp_prior;

  // Stage 1: capture flags, padded slots stay clear
  always_ff @(posedge clk_i) begin
    flag_q <= NPAD'(flags_i);
  end

  // Prefix OR inside each group of slots
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      pre_d[g*GRP] = flag_q[g*GRP];
      for (int j = 1; j < GRP; j++) begin
        pre_d[g*GRP+j] = pre_d[g*GRP+j-1] | flag_q[g*GRP+j];
      end
    end
  end

  // Stage 2: group prefixes and group hit bits
  always_ff @(posedge clk_i) begin
    pre_q <= pre_d;
    for (int g = 0; g < NGRP; g++) begin
      any_q[g] <= pre_d[g*GRP+GRP-1];
    end
  end

  // Any hit in an earlier group
  always_comb begin
    grp_prior[0] = 1'b0;
    for (int g = 1; g < NGRP; g++) begin
      grp_prior[g] = grp_prior[g-1] | any_q[g-1];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      mask_o[i] = pre_q[i] | grp_prior[i/GRP];
    end
  end

endmodule

`default_nettype wire

// ===== src/positional_sorted_list_engine.sv =====
// Top level of the positional sorted list engine: control, status and the cell chain.
// Depends on psl_pkg, psl_cell and psl_scan.
// A command goes through the flag, group and apply states before its result strobe.
// No new command is taken while busy: flag step, two search stages, shift step.
// Reset clears the record count and control; slot contents are not cleared.
// The result strobe lasts one cycle and cannot be stalled.
`default_nettype none

module positional_sorted_list_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  psl_pkg::psl_cmd_t  cmd_i,
  output logic               done_o,
  output psl_pkg::psl_rsp_t  rsp_o
);
  import psl_pkg::*;

  psl_state_e       state_q, state_d;
  psl_cmd_t         cmd_q;
  logic [CNT_W-1:0] count_q, count_d;
  psl_status_e      status_q, status_d;
  logic             done_q;
  psl_rsp_t         rsp_q;
  psl_op_e          op;
  logic             apply;
  logic             accept;

  logic [CMP_W-1:0] pos_ext, cnt_ext;
  logic             is_full, is_empty;

  psl_ctl_t              ctl;
  psl_upd_t              upd;
  psl_rec_t              new_rec;
  psl_rec_t              read_rec;
  psl_rec_t              recs  [CAPACITY];
  logic [CAPACITY-1:0]   flags;
  logic [CAPACITY-1:0]   mask;

  assign op      = psl_op_e'(cmd_q.op);
  assign accept  = start && !busy;
  assign pos_ext = CMP_W'(cmd_q.position);
  assign cnt_ext = CMP_W'(count_q);
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_FLAG;
      S_FLAG:  state_d = S_GROUP;
      S_GROUP: state_d = S_APPLY;
      S_APPLY: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    busy  = 1'b0;
    apply = 1'b0;
    case (state_q)
      S_IDLE:  busy = 1'b0;
      S_FLAG,
      S_GROUP: busy = 1'b1;
      S_APPLY: begin
        busy  = 1'b1;
        apply = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  // Status from the command and the count
  always_comb begin
    status_d = ST_OK;
    case (op)
      OP_INSERT: begin
        if (pos_ext > cnt_ext)  status_d = ST_BADPOS;
        else if (is_full)       status_d = ST_FULL;
      end
      OP_READ,
      OP_REMOVE: begin
        if (is_empty)            status_d = ST_EMPTY;
        else if (pos_ext >= cnt_ext) status_d = ST_BADPOS;
      end
      OP_SORTED: begin
        if (is_full) status_d = ST_FULL;
      end
      default: status_d = ST_OK;
    endcase
  end

  // Cell broadcasts
  assign ctl.sorted  = (op == OP_SORTED);
  assign ctl.count   = count_q;
  assign ctl.pos     = cmd_q.position;
  assign ctl.key     = cmd_q.key;
  assign upd.ins     = apply && (status_q == ST_OK) && ((op == OP_INSERT) || (op == OP_SORTED));
  assign upd.rem     = apply && (status_q == ST_OK) && (op == OP_REMOVE);
  assign new_rec.key     = cmd_q.key;
  assign new_rec.payload = cmd_q.payload[PAYLOAD_BITS-1:0];

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    psl_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(i)),
      .ctl_i       (ctl),
      .upd_i       (upd),
      .new_i       (new_rec),
      .left_i      ((i == 0) ? new_rec : recs[(i == 0) ? 0 : i-1]),
      .right_i     ((i == CAPACITY-1) ? recs[i] : recs[(i == CAPACITY-1) ? i : i+1]),
      .mask_i      (mask[i]),
      .mask_left_i ((i == 0) ? 1'b0 : mask[(i == 0) ? 0 : i-1]),
      .flag_o      (flags[i]),
      .rec_o       (recs[i])
    );
  end

  psl_scan u_scan (
    .clk_i   (clk_i),
    .flags_i (flags),
    .mask_o  (mask)
  );

  // Read select: the first slot of the mask
  always_comb begin
    read_rec = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (mask[i] && ((i == 0) || !mask[(i == 0) ? 0 : i-1])) begin
        read_rec = read_rec | recs[i];
      end
    end
  end

  // New count
  always_comb begin
    count_d = count_q;
    if (upd.ins)      count_d = count_q + CNT_W'(1);
    else if (upd.rem) count_d = count_q - CNT_W'(1);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= apply;
    end
  end

  // Command, status and response registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_FLAG) begin
      status_q <= status_d;
    end
    if (apply) begin
      rsp_q.status  <= status_q;
      rsp_q.entries <= ENT_W'(count_d);
      if ((status_q == ST_OK) && (op == OP_READ)) begin
        rsp_q.read_key     <= read_rec.key;
        rsp_q.read_payload <= PLD_W'(read_rec.payload);
      end else begin
        rsp_q.read_key     <= '0;
        rsp_q.read_payload <= '0;
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ===== dv/positional_sorted_list_engine_tb.sv =====
// Self-checking testbench for positional_sorted_list_engine: directed and random list commands.
// Depends on psl_pkg for the command, response, opcode and status types.
// Predicts every response from an in-bench copy of the list and checks each done strobe.
module positional_sorted_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psl_pkg::*;

  // One queued command with its sender pacing
  typedef struct {
    psl_cmd_t    cmd;
    int unsigned idle_pct;
    bit          drain;
  } list_txn_t;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  psl_cmd_t cmd_i  = '0;
  logic     done_o;
  psl_rsp_t rsp_o;

  positional_sorted_list_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  list_txn_t cmd_backlog_q[$];
  psl_rsp_t  pending_rsp_q[$];
  list_txn_t cur_txn;
  bit        have_txn  = 1'b0;
  bit        was_taken = 1'b0;
  int        n_taken   = 0;
  int        n_total   = 0;
  int        n_err     = 0;

  // Predicted list contents
  logic [KEY_W-1:0]        key_mem [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pld_mem [CAPACITY];
  int                      held = 0;

  // Generator pacing and count tracking
  int          gen_count = 0;
  int unsigned gen_idle  = 0;
  bit          gen_drain = 1'b0;

  // Open a slot at idx and store the record there
  function automatic void shift_in(input int idx, input logic [KEY_W-1:0] k,
                                   input logic [PLD_W-1:0] p);
    for (int i = held; i > idx; i--) begin
      key_mem[i] = key_mem[i-1];
      pld_mem[i] = pld_mem[i-1];
    end
    key_mem[idx] = k;
    pld_mem[idx] = p[PAYLOAD_BITS-1:0];
    held++;
  endfunction

  // Apply one command to the predicted list and return the response it gives
  function automatic psl_rsp_t list_apply(input psl_cmd_t c);
    psl_rsp_t r;
    int       slot;
    r        = '0;
    r.status = ST_OK;
    case (psl_op_e'(c.op))
      OP_INSERT: begin
        if (c.position > held) r.status = ST_BADPOS;
        else if (held >= CAPACITY) r.status = ST_FULL;
        else shift_in(c.position, c.key, c.payload);
      end
      OP_READ: begin
        if (held == 0) r.status = ST_EMPTY;
        else if (c.position >= held) r.status = ST_BADPOS;
        else begin
          r.read_key     = key_mem[c.position];
          r.read_payload = PLD_W'(pld_mem[c.position]);
        end
      end
      OP_REMOVE: begin
        if (held == 0) r.status = ST_EMPTY;
        else if (c.position >= held) r.status = ST_BADPOS;
        else begin
          for (int i = c.position; i + 1 < held; i++) begin
            key_mem[i] = key_mem[i+1];
            pld_mem[i] = pld_mem[i+1];
          end
          held--;
        end
      end
      default: begin
        // equal keys land before the first match
        if (held >= CAPACITY) r.status = ST_FULL;
        else begin
          slot = 0;
          while (slot < held && key_mem[slot] < c.key) slot++;
          shift_in(slot, c.key, c.payload);
        end
      end
    endcase
    r.entries = ENT_W'(held);
    return r;
  endfunction

  task automatic check_field(input string fld, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
      n_err++;
    end
  endtask

  // Queue one command; track the count so positions can aim at the live list
  task automatic queue_cmd(input psl_op_e op, input int pos, input logic [KEY_W-1:0] k,
                           input logic [PLD_W-1:0] p);
    list_txn_t t;
    t.cmd.op       = op;
    t.cmd.position = POS_W'(pos);
    t.cmd.key      = k;
    t.cmd.payload  = p;
    t.idle_pct     = gen_idle;
    t.drain        = gen_drain;
    gen_drain      = 1'b0;
    cmd_backlog_q.push_back(t);
    case (op)
      OP_INSERT: if (pos <= gen_count && gen_count < CAPACITY) gen_count++;
      OP_REMOVE: if (gen_count > 0 && pos < gen_count) gen_count--;
      OP_SORTED: if (gen_count < CAPACITY) gen_count++;
      default: ;
    endcase
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(7);
    case (r)
      0:       return '0;
      1:       return '1;
      2, 3:    return KEY_W'($urandom_range(15));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic logic [PLD_W-1:0] pick_payload();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Position aimed inside the list, with some noise over the whole field
  function automatic int pick_pos(input bit allow_tail);
    if ($urandom_range(9) == 0) return $urandom_range(127);
    if (allow_tail) return $urandom_range(gen_count);
    if (gen_count == 0) return 0;
    return $urandom_range(gen_count - 1);
  endfunction

  // Driver: changes inputs on the falling edge
  always @(negedge clk_i) begin : drv
    bit offer;
    offer = 1'b0;
    if (rst_ni) begin
      if (was_taken) have_txn = 1'b0;
      if (!have_txn && cmd_backlog_q.size() != 0) begin
        cur_txn  = cmd_backlog_q.pop_front();
        have_txn = 1'b1;
      end
      if (have_txn) begin
        if (cur_txn.drain && pending_rsp_q.size() != 0) offer = 1'b0;
        else if ($urandom_range(99) < cur_txn.idle_pct) offer = 1'b0;
        else offer = 1'b1;
      end
    end
    start <= offer;
    if (offer) cmd_i <= cur_txn.cmd;
  end

  // Monitor: checks responses first, then predicts for the transaction taken at this edge
  always @(posedge clk_i) begin : mon
    psl_rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: response with none expected, actual %0h", $time, rsp_o);
          n_err++;
        end else begin
          want = pending_rsp_q.pop_front();
          check_field("status", want.status, rsp_o.status);
          check_field("read_key", want.read_key, rsp_o.read_key);
          check_field("read_payload", want.read_payload, rsp_o.read_payload);
          check_field("entries", want.entries, rsp_o.entries);
        end
      end
      if (start && !busy) begin
        pending_rsp_q.push_back(list_apply(cmd_i));
        n_taken++;
      end
      was_taken <= start && !busy;
    end else begin
      was_taken <= 1'b0;
    end
  end

  // Stimulus, reset and end of run
  initial begin : stim
    int n_gen;
    int mode;
    int run_len;
    int phase;
    int unsigned pick;
    int unsigned idle_tab [4];
    idle_tab = '{0, 51, 0, 19};

    // Directed: empty list, bad positions, equal keys, head, tail, count-1
    queue_cmd(OP_READ, 0, '0, '0);
    queue_cmd(OP_REMOVE, 0, '0, '0);
    queue_cmd(OP_INSERT, 1, 16'h1111, 32'h1111_1111);
    queue_cmd(OP_INSERT, 127, 16'h2222, 32'h2222_2222);
    queue_cmd(OP_SORTED, 0, 16'h8000, 32'hffff_ffff);
    queue_cmd(OP_SORTED, 127, 16'h8000, 32'h0000_0000);
    queue_cmd(OP_SORTED, 0, 16'h0000, 32'ha5a5_a5a5);
    queue_cmd(OP_SORTED, 0, 16'hffff, 32'h5a5a_5a5a);
    queue_cmd(OP_INSERT, 0, 16'h1234, 32'h0123_4567);
    queue_cmd(OP_INSERT, gen_count - 1, 16'h4321, 32'h89ab_cdef);
    queue_cmd(OP_INSERT, gen_count, 16'hffff, 32'h0000_0000);
    queue_cmd(OP_READ, 0, '0, '0);
    queue_cmd(OP_READ, 3, '0, '0);
    queue_cmd(OP_READ, gen_count - 1, '1, '1);
    queue_cmd(OP_READ, gen_count, '0, '0);
    queue_cmd(OP_READ, 127, '0, '0);
    queue_cmd(OP_REMOVE, gen_count, '0, '0);
    queue_cmd(OP_REMOVE, 64, '0, '0);
    queue_cmd(OP_REMOVE, 0, '0, '0);
    queue_cmd(OP_REMOVE, gen_count - 1, '0, '0);
    queue_cmd(OP_READ, 0, '0, '0);
    queue_cmd(OP_SORTED, 64, 16'h7fff, 32'h7fff_ffff);
    queue_cmd(OP_READ, 2, '0, '0);

    // Random runs of fill, drain, mixed noise and fill-to-full bursts
    n_gen = 0;
    phase = -1;
    while (n_gen < 850) begin
      if (n_gen * 4 / 850 != phase) begin
        phase     = n_gen * 4 / 850;
        gen_idle  = idle_tab[phase];
        gen_drain = 1'b1;
      end
      mode    = $urandom_range(3);
      run_len = $urandom_range(60, 10);
      if (mode == 3) begin
        while (gen_count < CAPACITY) begin
          if ($urandom_range(1)) queue_cmd(OP_SORTED, $urandom_range(127), pick_key(),
                                           pick_payload());
          else queue_cmd(OP_INSERT, $urandom_range(gen_count), pick_key(), pick_payload());
          n_gen++;
        end
        // hammer the full list: valid and invalid positions, sorted, reads near the end
        queue_cmd(OP_INSERT, $urandom_range(CAPACITY), pick_key(), pick_payload());
        queue_cmd(OP_INSERT, $urandom_range(127, CAPACITY + 1), pick_key(), pick_payload());
        queue_cmd(OP_SORTED, 0, pick_key(), pick_payload());
        queue_cmd(OP_READ, CAPACITY - 1, '0, '0);
        queue_cmd(OP_READ, CAPACITY, '0, '0);
        queue_cmd(OP_REMOVE, CAPACITY, '0, '0);
        n_gen += 6;
      end else begin
        for (int j = 0; j < run_len; j++) begin
          pick = $urandom_range(99);
          if (mode == 0) begin
            if (pick < 38) queue_cmd(OP_INSERT, pick_pos(1'b1), pick_key(), pick_payload());
            else if (pick < 75) queue_cmd(OP_SORTED, $urandom_range(127), pick_key(),
                                          pick_payload());
            else queue_cmd(OP_READ, pick_pos(1'b0), pick_key(), pick_payload());
          end else if (mode == 1) begin
            if (pick < 70) queue_cmd(OP_REMOVE, pick_pos(1'b0), pick_key(), pick_payload());
            else queue_cmd(OP_READ, pick_pos(1'b0), pick_key(), pick_payload());
          end else begin
            queue_cmd(psl_op_e'($urandom_range(3)), $urandom_range(127), pick_key(),
                      pick_payload());
          end
          n_gen++;
          if ($urandom_range(99) == 0) gen_drain = 1'b1;
        end
      end
    end
    n_total = cmd_backlog_q.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    wait (n_taken == n_total);
    wait (pending_rsp_q.size() == 0);
    repeat (8) @(posedge clk_i);
    if (pending_rsp_q.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, pending_rsp_q.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
